### rtl/tdfe_pkg.sv
// ----------------------------------------------------------------------------
// tdfe_pkg
// Command codes and shared types for the tube digit fade engine.
// ----------------------------------------------------------------------------
package tdfe_pkg;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_TICK     = 3'd0;
  localparam cmd_t CMD_SET      = 3'd1;
  localparam cmd_t CMD_CLEAR    = 3'd2;
  localparam cmd_t CMD_FADE_IN  = 3'd3;
  localparam cmd_t CMD_FADE_OUT = 3'd4;
  localparam cmd_t CMD_FOG_IN   = 3'd5;
  localparam cmd_t CMD_FOG_OUT  = 3'd6;

  // The running effect is held as its command code; tick doubles as idle.
  localparam cmd_t MODE_IDLE    = CMD_TICK;

endpackage

### rtl/tube_digit_fade_engine.sv
// ----------------------------------------------------------------------------
// tube_digit_fade_engine
// Brightness store and fade/fog sequencer for a bank of display tubes.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time: a tick or a command. Every digit
// brightness lives in a single-port-read, single-port-write memory of
// NUM_TUBES*DIGITS_PER_TUBE entries with a registered read, so tube-wide
// work is a read-modify-write walk over that memory. A tick that does not
// step, a fog-in start and an ignored command finish in the accept cycle. A
// single-digit write (set, fade start, fade step) goes through ST_ONE, which
// writes the memory and loads the output register. Clear and fog-out start
// take the accept cycle and then walk the tube, a read state (ST_WALK_RD)
// and a write state (ST_WALK_WR) per digit. A fog step first scans the tube
// with pipelined reads to learn whether it is the final step and then walks
// it; the memory read port sets this pacing. in_ready is high whenever the
// sequencer is idle, even while the last result of the previous transaction
// still waits in the output register. Output stalls hold the sequencer in
// its write states. Reset clears a per-entry valid vector, so the store
// reads as zero at once and no clearing pass is needed.
// ----------------------------------------------------------------------------
module tube_digit_fade_engine
  import tdfe_pkg::*;
#(
  parameter int NUM_TUBES       = 6,
  parameter int DIGITS_PER_TUBE = 10,
  parameter int MAX_LEVEL       = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [2:0]  in_tube_index,
  input  logic [3:0]  in_digit_index,
  input  logic [3:0]  in_level,
  input  logic [15:0] in_step_delay,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_valid,
  output logic [2:0]  out_tube,
  output logic [3:0]  out_digit,
  output logic [3:0]  out_level,
  output logic        out_busy_res,
  output logic        out_last
);

  localparam int NCELL = NUM_TUBES * DIGITS_PER_TUBE;
  localparam int AW    = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int CW    = $clog2(DIGITS_PER_TUBE + 1);
  localparam logic [3:0]    MAX_LVL  = 4'(MAX_LEVEL);
  localparam logic [CW-1:0] LAST_DIG = CW'(DIGITS_PER_TUBE - 1);
  localparam logic [CW-1:0] NUM_DIG  = CW'(DIGITS_PER_TUBE);

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ONE     = 3'd1;
  localparam logic [2:0] ST_SCAN    = 3'd2;
  localparam logic [2:0] ST_WALK_RD = 3'd3;
  localparam logic [2:0] ST_WALK_WR = 3'd4;

  // Row walk kinds
  localparam logic [1:0] WK_CONST   = 2'd0;
  localparam logic [1:0] WK_FOG_IN  = 2'd1;
  localparam logic [1:0] WK_FOG_OUT = 2'd2;

  // --------------------------------------------------------------------------
  // Brightness store: array memory, registered read, valid bits for reset.
  // --------------------------------------------------------------------------
  logic [3:0]       mem [NCELL];
  logic [NCELL-1:0] vld_r;
  logic [3:0]       rd_data_r;
  logic             rd_vld_r;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic [3:0]       mem_wdata;
  logic [3:0]       rd_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
      rd_vld_r  <= vld_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_waddr] <= 1'b1;
    end
  end

  // An entry never written since reset reads as zero.
  assign rd_val = rd_vld_r ? rd_data_r : 4'd0;

  // --------------------------------------------------------------------------
  // Fog step arithmetic, shared by the scan and the write-back walk.
  // --------------------------------------------------------------------------
  function automatic logic [3:0] fog_next(input logic [1:0] kind, input logic [3:0] v,
                                          input logic held);
    logic [3:0] r;
    r = v;
    if (kind == WK_FOG_IN) begin
      r = (v < MAX_LVL) ? v + 4'd1 : MAX_LVL;
    end else if (held) begin
      r = MAX_LVL;
    end else begin
      r = (v != 4'd0) ? v - 4'd1 : 4'd0;
    end
    return r;
  endfunction

  // Digit is finished once this step leaves it at its final level.
  function automatic logic fog_settled(input logic [1:0] kind, input logic [3:0] v,
                                       input logic held);
    logic [3:0] n;
    logic       ok;
    n  = fog_next(kind, v, held);
    ok = (kind == WK_FOG_IN) ? (n == MAX_LVL) : (held || n == 4'd0);
    return ok;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [2:0]    state_r,     state_nxt;
  cmd_t          mode_r,      mode_nxt;
  logic [2:0]    act_tube_r,  act_tube_nxt;
  logic [3:0]    act_digit_r, act_digit_nxt;
  logic [15:0]   delay_r,     delay_nxt;
  logic [15:0]   elapsed_r,   elapsed_nxt;
  logic [3:0]    cur_lvl_r,   cur_lvl_nxt;

  logic [1:0]    wk_kind_r,   wk_kind_nxt;
  logic [3:0]    wk_val_r,    wk_val_nxt;
  logic [2:0]    wk_tube_r,   wk_tube_nxt;
  logic [AW-1:0] wk_base_r,   wk_base_nxt;
  logic [3:0]    wk_held_r,   wk_held_nxt;
  logic [CW-1:0] cnt_r,       cnt_nxt;
  logic          pend_r,      pend_nxt;
  logic [CW-1:0] pend_idx_r,  pend_idx_nxt;
  logic          done_acc_r,  done_acc_nxt;
  logic          busy_r,      busy_nxt;

  logic [AW-1:0] one_addr_r,  one_addr_nxt;
  logic [2:0]    one_tube_r,  one_tube_nxt;
  logic [3:0]    one_digit_r, one_digit_nxt;
  logic [3:0]    one_lvl_r,   one_lvl_nxt;

  logic          out_valid_r;
  logic [2:0]    out_tube_r;
  logic [3:0]    out_digit_r;
  logic [3:0]    out_level_r;
  logic          out_busy_r;
  logic          out_last_r;

  // Output register load
  logic          ld;
  logic [2:0]    ld_tube;
  logic [3:0]    ld_digit;
  logic [3:0]    ld_lvl;
  logic          ld_last;

  logic          out_free;
  logic          in_acc;
  logic          tube_ok;
  logic          dig_ok;
  logic [15:0]   el_inc;
  logic [3:0]    step_lvl;
  logic          step_end;
  logic          scan_ok;
  logic [3:0]    walk_new;
  logic [AW-1:0] in_base;
  logic [AW-1:0] act_base;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign tube_ok  = (32'(in_tube_index) < NUM_TUBES);
  assign dig_ok   = (32'(in_digit_index) < DIGITS_PER_TUBE);
  assign in_base  = AW'(32'(in_tube_index) * DIGITS_PER_TUBE);
  assign act_base = AW'(32'(act_tube_r) * DIGITS_PER_TUBE);
  assign el_inc   = (elapsed_r != 16'hFFFF) ? elapsed_r + 16'd1 : elapsed_r;

  // Single-digit fade step
  always_comb begin
    step_lvl = cur_lvl_r;
    step_end = 1'b0;
    if (mode_r == CMD_FADE_IN) begin
      step_lvl = (cur_lvl_r < MAX_LVL) ? cur_lvl_r + 4'd1 : cur_lvl_r;
      step_end = (step_lvl >= MAX_LVL);
    end else begin
      step_lvl = (cur_lvl_r != 4'd0) ? cur_lvl_r - 4'd1 : 4'd0;
      step_end = (step_lvl == 4'd0);
    end
  end

  assign scan_ok  = fog_settled(wk_kind_r, rd_val, 4'(pend_idx_r) == wk_held_r);
  assign walk_new = (wk_kind_r == WK_CONST) ? wk_val_r
                  : fog_next(wk_kind_r, rd_val, 4'(cnt_r) == wk_held_r);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    act_tube_nxt  = act_tube_r;
    act_digit_nxt = act_digit_r;
    delay_nxt     = delay_r;
    elapsed_nxt   = elapsed_r;
    cur_lvl_nxt   = cur_lvl_r;
    wk_kind_nxt   = wk_kind_r;
    wk_val_nxt    = wk_val_r;
    wk_tube_nxt   = wk_tube_r;
    wk_base_nxt   = wk_base_r;
    wk_held_nxt   = wk_held_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    done_acc_nxt  = done_acc_r;
    busy_nxt      = busy_r;
    one_addr_nxt  = one_addr_r;
    one_tube_nxt  = one_tube_r;
    one_digit_nxt = one_digit_r;
    one_lvl_nxt   = one_lvl_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = one_addr_r;
    mem_raddr     = wk_base_r + AW'(cnt_r);
    mem_wdata     = one_lvl_r;
    ld            = 1'b0;
    ld_tube       = one_tube_r;
    ld_digit      = one_digit_r;
    ld_lvl        = one_lvl_r;
    ld_last       = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_TICK) begin
            // Advance the running effect; ticks while idle are dropped.
            if (mode_r != MODE_IDLE) begin
              if (el_inc >= delay_r) begin
                elapsed_nxt = 16'd0;
                if (mode_r == CMD_FADE_IN || mode_r == CMD_FADE_OUT) begin
                  cur_lvl_nxt   = step_lvl;
                  mode_nxt      = step_end ? MODE_IDLE : mode_r;
                  busy_nxt      = !step_end;
                  one_addr_nxt  = act_base + AW'(act_digit_r);
                  one_tube_nxt  = act_tube_r;
                  one_digit_nxt = act_digit_r;
                  one_lvl_nxt   = step_lvl;
                  state_nxt     = ST_ONE;
                end else begin
                  wk_kind_nxt  = (mode_r == CMD_FOG_IN) ? WK_FOG_IN : WK_FOG_OUT;
                  wk_tube_nxt  = act_tube_r;
                  wk_base_nxt  = act_base;
                  wk_held_nxt  = act_digit_r;
                  cnt_nxt      = '0;
                  done_acc_nxt = 1'b1;
                  state_nxt    = ST_SCAN;
                end
              end else begin
                elapsed_nxt = el_inc;
              end
            end
          end else if (tube_ok && in_command <= CMD_FOG_OUT &&
                       (dig_ok || in_command == CMD_CLEAR || in_command == CMD_FOG_IN)) begin
            mode_nxt = MODE_IDLE;
            unique case (in_command)
              CMD_SET: begin
                busy_nxt      = 1'b0;
                one_addr_nxt  = in_base + AW'(in_digit_index);
                one_tube_nxt  = in_tube_index;
                one_digit_nxt = in_digit_index;
                one_lvl_nxt   = (in_level > MAX_LVL) ? MAX_LVL : in_level;
                state_nxt     = ST_ONE;
              end
              CMD_CLEAR: begin
                busy_nxt    = 1'b0;
                wk_kind_nxt = WK_CONST;
                wk_val_nxt  = 4'd0;
                wk_tube_nxt = in_tube_index;
                wk_base_nxt = in_base;
                cnt_nxt     = '0;
                state_nxt   = ST_WALK_RD;
              end
              default: begin
                // Fade and fog starts load the effect context.
                mode_nxt      = in_command;
                act_tube_nxt  = in_tube_index;
                act_digit_nxt = (in_command == CMD_FOG_IN) ? 4'd0 : in_digit_index;
                delay_nxt     = in_step_delay;
                elapsed_nxt   = 16'd0;
                busy_nxt      = 1'b1;
                if (in_command == CMD_FADE_IN || in_command == CMD_FADE_OUT) begin
                  cur_lvl_nxt   = (in_command == CMD_FADE_IN) ? 4'd0 : MAX_LVL;
                  one_addr_nxt  = in_base + AW'(in_digit_index);
                  one_tube_nxt  = in_tube_index;
                  one_digit_nxt = in_digit_index;
                  one_lvl_nxt   = (in_command == CMD_FADE_IN) ? 4'd0 : MAX_LVL;
                  state_nxt     = ST_ONE;
                end else if (in_command == CMD_FOG_OUT) begin
                  wk_kind_nxt = WK_CONST;
                  wk_val_nxt  = MAX_LVL;
                  wk_tube_nxt = in_tube_index;
                  wk_base_nxt = in_base;
                  cnt_nxt     = '0;
                  state_nxt   = ST_WALK_RD;
                end
              end
            endcase
          end
        end
      end

      ST_ONE: begin
        if (out_free) begin
          mem_we    = 1'b1;
          ld        = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // Pipelined reads: issue one digit, check the one issued before.
        mem_re       = (cnt_r < NUM_DIG);
        cnt_nxt      = mem_re ? cnt_r + CW'(1) : cnt_r;
        pend_nxt     = mem_re;
        pend_idx_nxt = cnt_r;
        if (pend_r) begin
          done_acc_nxt = done_acc_r && scan_ok;
          if (pend_idx_r == LAST_DIG) begin
            mode_nxt  = (done_acc_r && scan_ok) ? MODE_IDLE : mode_r;
            busy_nxt  = !(done_acc_r && scan_ok);
            cnt_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = ST_WALK_RD;
          end
        end
      end

      ST_WALK_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_WALK_WR;
      end

      ST_WALK_WR: begin
        mem_waddr = wk_base_r + AW'(cnt_r);
        mem_wdata = walk_new;
        ld_tube   = wk_tube_r;
        ld_digit  = 4'(cnt_r);
        ld_lvl    = walk_new;
        ld_last   = (cnt_r == LAST_DIG);
        if (out_free) begin
          mem_we = 1'b1;
          ld     = 1'b1;
          if (cnt_r == LAST_DIG) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = ST_WALK_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_IDLE;
      act_tube_r  <= '0;
      act_digit_r <= '0;
      delay_r     <= '0;
      elapsed_r   <= '0;
      cur_lvl_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      act_tube_r  <= act_tube_nxt;
      act_digit_r <= act_digit_nxt;
      delay_r     <= delay_nxt;
      elapsed_r   <= elapsed_nxt;
      cur_lvl_r   <= cur_lvl_nxt;
      pend_r      <= pend_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk context and output payload
  always_ff @(posedge clk) begin
    wk_kind_r   <= wk_kind_nxt;
    wk_val_r    <= wk_val_nxt;
    wk_tube_r   <= wk_tube_nxt;
    wk_base_r   <= wk_base_nxt;
    wk_held_r   <= wk_held_nxt;
    cnt_r       <= cnt_nxt;
    pend_idx_r  <= pend_idx_nxt;
    done_acc_r  <= done_acc_nxt;
    busy_r      <= busy_nxt;
    one_addr_r  <= one_addr_nxt;
    one_tube_r  <= one_tube_nxt;
    one_digit_r <= one_digit_nxt;
    one_lvl_r   <= one_lvl_nxt;
    if (ld) begin
      out_tube_r  <= ld_tube;
      out_digit_r <= ld_digit;
      out_level_r <= ld_lvl;
      out_busy_r  <= busy_nxt;
      out_last_r  <= ld_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_write_valid = 1'b1;
  assign out_tube        = out_tube_r;
  assign out_digit       = out_digit_r;
  assign out_level       = out_level_r;
  assign out_busy_res    = out_busy_r;
  assign out_last        = out_last_r;

endmodule

### rtl/tdfe_checker.sv
// ----------------------------------------------------------------------------
// tdfe_checker
// Port-level checks for the tube digit fade engine, bound to the top level.
// ----------------------------------------------------------------------------
module tdfe_checker
  import tdfe_pkg::*;
#(
  parameter int NUM_TUBES       = 6,
  parameter int DIGITS_PER_TUBE = 10,
  parameter int MAX_LEVEL       = 8
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_command,
  input logic [2:0]  in_tube_index,
  input logic [3:0]  in_digit_index,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_write_valid,
  input logic [2:0]  out_tube,
  input logic [3:0]  out_digit,
  input logic [3:0]  out_level,
  input logic        out_busy_res,
  input logic        out_last
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_digit)
      && $stable(out_tube) && $stable(out_last) && $stable(out_busy_res))
    else $error("result changed while stalled");

  // A written digit always lies inside the display.
  a_out_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_tube) < NUM_TUBES && 32'(out_digit) < DIGITS_PER_TUBE)
    else $error("result addresses a digit outside the display");

  // Levels never exceed full brightness.
  a_out_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_level) <= MAX_LEVEL && out_write_valid)
    else $error("result level above full brightness");

  // A valid set-digit owes a result, so the engine is busy right after.
  a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_SET && 32'(in_tube_index) < NUM_TUBES
      && 32'(in_digit_index) < DIGITS_PER_TUBE |=> !in_ready)
    else $error("engine ready again before writing a set digit");

endmodule

bind tube_digit_fade_engine tdfe_checker #(
  .NUM_TUBES      (NUM_TUBES),
  .DIGITS_PER_TUBE(DIGITS_PER_TUBE),
  .MAX_LEVEL      (MAX_LEVEL)
) u_tdfe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_command     (in_command),
  .in_tube_index  (in_tube_index),
  .in_digit_index (in_digit_index),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_write_valid(out_write_valid),
  .out_tube       (out_tube),
  .out_digit      (out_digit),
  .out_level      (out_level),
  .out_busy_res   (out_busy_res),
  .out_last       (out_last)
);
